### sv/fdh_pkg.sv
// shared types and constants for the feedback delay with hold
// used by fdh_ctrl, fdh_datapath and feedback_delay_with_hold; no dependencies
`timescale 1ns / 1ps

package fdh_pkg;

    // fixed field widths
    localparam int TARGET_W = 34;
    localparam int GAIN_W   = 17;
    localparam int SMOOTH_W = 50;
    localparam int FRAC_W   = 16;
    localparam int WHOLE_W  = SMOOTH_W - 32;

    // fixed-point constants
    localparam logic [10:0]       SMOOTH_COEF = 11'd1678;   // 0.0001 in q0.24
    localparam logic [15:0]       WET_SCALE   = 16'd58982;  // 0.9 in q0.16
    localparam logic [GAIN_W-1:0] UNITY       = 17'd65536;

    // controller states, one-hot
    typedef enum logic [10:0] {
        S_CLEAR  = 11'b000_0000_0001,
        S_IDLE   = 11'b000_0000_0010,
        S_SMUL   = 11'b000_0000_0100,
        S_SUPD   = 11'b000_0000_1000,
        S_ADDR   = 11'b000_0001_0000,
        S_RDA    = 11'b000_0010_0000,
        S_RDB    = 11'b000_0100_0000,
        S_IMUL   = 11'b000_1000_0000,
        S_RSUM   = 11'b001_0000_0000,
        S_PMUL   = 11'b010_0000_0000,
        S_COMMIT = 11'b100_0000_0000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clear_wr;
        logic capture;
        logic smooth_mul;
        logic smooth_upd;
        logic addr_calc;
        logic rd_a;
        logic rd_b;
        logic interp_mul;
        logic rd_sum;
        logic prod_mul;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic out_busy;
    } t_sts;

endpackage

### sv/fdh_ctrl.sv
// sequencing state machine for the feedback delay with hold
// depends on fdh_pkg
`timescale 1ns / 1ps

module fdh_ctrl
    import fdh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.capture = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = S_SMUL;
                end
            end
            S_SMUL: begin
                o_cmd.smooth_mul = 1'b1;
                n_state          = S_SUPD;
            end
            S_SUPD: begin
                o_cmd.smooth_upd = 1'b1;
                n_state          = S_ADDR;
            end
            S_ADDR: begin
                o_cmd.addr_calc = 1'b1;
                n_state         = S_RDA;
            end
            S_RDA: begin
                o_cmd.rd_a = 1'b1;
                n_state    = S_RDB;
            end
            S_RDB: begin
                o_cmd.rd_b = 1'b1;
                n_state    = S_IMUL;
            end
            S_IMUL: begin
                o_cmd.interp_mul = 1'b1;
                n_state          = S_RSUM;
            end
            S_RSUM: begin
                o_cmd.rd_sum = 1'b1;
                n_state      = S_PMUL;
            end
            S_PMUL: begin
                o_cmd.prod_mul = 1'b1;
                n_state        = S_COMMIT;
            end
            S_COMMIT: begin
                // wait here while the previous result is still unclaimed
                if (!i_sts.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);

endmodule

### sv/fdh_datapath.sv
// delay store, smoothing, interpolation, feedback and mix arithmetic
// depends on fdh_pkg; sequenced by fdh_ctrl through t_cmd / t_sts
`timescale 1ns / 1ps

module fdh_datapath
    import fdh_pkg::*;
#(
    parameter int DELAY_DEPTH  = 262144,
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cmd                           i_cmd,
    output t_sts                           o_sts,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample_in,
    input  logic        [TARGET_W-1:0]     i_delay_target,
    input  logic        [GAIN_W-1:0]       i_feedback_gain,
    input  logic        [GAIN_W-1:0]       i_mix_level,
    input  logic                           i_hold,
    output logic signed [SAMPLE_WIDTH-1:0] o_sample_out,
    output logic                           o_out_valid,
    input  logic                           i_out_ready
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int AW   = $clog2(DELAY_DEPTH);
    localparam int WW   = ((AW > WHOLE_W) ? AW : WHOLE_W) + 1;
    localparam int ACCW = SW + 35;

    function automatic logic signed [SW-1:0] sat(input logic signed [SW+2:0] v);
        logic fits;
        fits = (v[SW+2:SW-1] == '0) || (v[SW+2:SW-1] == '1);
        if (fits) begin
            sat = v[SW-1:0];
        end else if (v[SW+2]) begin
            sat = {1'b1, {(SW-1){1'b0}}};
        end else begin
            sat = {1'b0, {(SW-1){1'b1}}};
        end
    endfunction

    // delay store
    logic signed [SW-1:0] mem [DELAY_DEPTH];
    logic signed [SW-1:0] r_q;

    // control state
    logic [AW-1:0]       r_clr_addr;
    logic [AW-1:0]       r_wi;
    logic [SMOOTH_W-1:0] r_smooth;
    logic                r_out_valid;

    // payload registers
    logic signed [SW-1:0]    r_dry;
    logic [TARGET_W-1:0]     r_target;
    logic [GAIN_W-1:0]       r_fb;
    logic [GAIN_W-1:0]       r_mix;
    logic                    r_hold;
    logic [36:0]             r_step;
    logic                    r_up;
    logic [31:0]             r_mixw;
    logic signed [SW+17:0]   r_dryp;
    logic [AW-1:0]           r_ia;
    logic [AW-1:0]           r_ib;
    logic signed [SW-1:0]    r_a;
    logic signed [SW+17:0]   r_ip;
    logic signed [SW-1:0]    r_rd;
    logic signed [SW+17:0]   r_fbp;
    logic signed [SW+32:0]   r_wet;
    logic signed [SW-1:0]    r_out;

    // combinational
    logic [SMOOTH_W-1:0]   target_q;
    logic [SMOOTH_W-1:0]   mag;
    logic [60:0]           step_full;
    logic [32:0]           mixw_full;
    logic [GAIN_W-1:0]     inv_mix;
    logic [WW-1:0]         whole_w;
    logic [WW-1:0]         whole_c;
    logic [WW-1:0]         sum_a;
    logic [WW-1:0]         ia_w;
    logic [AW-1:0]         ia;
    logic signed [SW:0]    bdiff;
    logic signed [SW:0]    rd_w;
    logic signed [SW+2:0]  fb_sum;
    logic signed [SW-1:0]  wv;
    logic signed [ACCW-1:0] acc;
    logic signed [SW+2:0]  acc_sh;
    logic                  we;
    logic [AW-1:0]         waddr;
    logic signed [SW-1:0]  wdata;
    logic [AW-1:0]         raddr;

    // smoothing: step = |target - smoothed| * coef >> 24
    assign target_q  = {r_target, 16'b0};
    assign mag       = (target_q >= r_smooth) ? (target_q - r_smooth) : (r_smooth - target_q);
    assign step_full = 61'(mag) * 61'(SMOOTH_COEF);
    assign mixw_full = 33'(r_mix) * 33'(WET_SCALE);
    assign inv_mix   = UNITY - r_mix;

    // read addresses, whole part clamped to the store
    assign whole_w = WW'(r_smooth[SMOOTH_W-1:32]);
    assign whole_c = (whole_w >= WW'(DELAY_DEPTH)) ? WW'(DELAY_DEPTH - 1) : whole_w;
    assign sum_a   = WW'(r_wi) + whole_c;
    assign ia_w    = (sum_a >= WW'(DELAY_DEPTH)) ? (sum_a - WW'(DELAY_DEPTH)) : sum_a;
    assign ia      = ia_w[AW-1:0];

    // interpolation, r_q holds b during interp_mul
    assign bdiff = (SW+1)'(r_q) - (SW+1)'(r_a);
    assign rd_w  = (SW+1)'(r_a) + (SW+1)'(r_ip >>> FRAC_W);

    // write-back value and output
    assign fb_sum = (SW+3)'(r_fbp >>> FRAC_W) + (SW+3)'(r_dry);
    assign wv     = r_hold ? r_rd : sat(fb_sum);
    assign acc    = ACCW'(r_wet) + (ACCW'(r_dryp) <<< 16);
    assign acc_sh = acc[ACCW-1:32];

    assign we    = i_cmd.clear_wr | i_cmd.commit;
    assign waddr = i_cmd.clear_wr ? r_clr_addr : r_wi;
    assign wdata = i_cmd.clear_wr ? '0 : wv;
    assign raddr = i_cmd.rd_b ? r_ib : r_ia;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (i_cmd.rd_a || i_cmd.rd_b) begin
            r_q <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_wi        <= '0;
            r_smooth    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_wr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.smooth_upd) begin
                r_smooth <= r_up ? (r_smooth + SMOOTH_W'(r_step))
                                 : (r_smooth - SMOOTH_W'(r_step));
            end
            if (i_cmd.commit) begin
                r_wi <= (r_wi == '0) ? AW'(DELAY_DEPTH - 1) : (r_wi - 1'b1);
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_dry    <= i_sample_in;
            r_target <= i_delay_target;
            r_fb     <= (i_feedback_gain > UNITY) ? UNITY : i_feedback_gain;
            r_mix    <= (i_mix_level > UNITY) ? UNITY : i_mix_level;
            r_hold   <= i_hold;
        end
        if (i_cmd.smooth_mul) begin
            r_step <= step_full[60:24];
            r_up   <= (target_q >= r_smooth);
            r_mixw <= mixw_full[31:0];
            r_dryp <= r_dry * $signed({1'b0, inv_mix});
        end
        if (i_cmd.addr_calc) begin
            r_ia <= ia;
            r_ib <= (ia == AW'(DELAY_DEPTH - 1)) ? '0 : (ia + 1'b1);
        end
        if (i_cmd.rd_b) begin
            r_a <= r_q;
        end
        if (i_cmd.interp_mul) begin
            r_ip <= bdiff * $signed({1'b0, r_smooth[31:16]});
        end
        if (i_cmd.rd_sum) begin
            r_rd <= rd_w[SW-1:0];
        end
        if (i_cmd.prod_mul) begin
            r_fbp <= r_rd * $signed({1'b0, r_fb});
            r_wet <= r_rd * $signed({1'b0, r_mixw});
        end
        if (i_cmd.commit) begin
            r_out <= sat(acc_sh);
        end
    end

    assign o_sts.clear_last = (r_clr_addr == AW'(DELAY_DEPTH - 1));
    assign o_sts.out_busy   = r_out_valid & ~i_out_ready;
    assign o_sample_out     = r_out;
    assign o_out_valid      = r_out_valid;

endmodule

### sv/feedback_delay_with_hold.sv
// feedback delay with hold: one item at a time; the input reopens once the
// item is committed, which waits while the previous result is unclaimed;
// the store's read port serializes two reads and the write comes at commit,
// and the multiplier stages (smoothing, interpolation, gain) are registered.
// after reset a clearing pass writes zero to all DELAY_DEPTH store entries,
// one per cycle, before the first transaction is taken. sync active-low reset.
`timescale 1ns / 1ps

module feedback_delay_with_hold
    import fdh_pkg::*;
#(
    parameter int DELAY_DEPTH  = 262144,
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic i_clk,
    input  logic i_rst_n,

    // input stream
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // sample_in, delay_target, feedback_gain, mix_level, zero pad
    input  logic [((SAMPLE_WIDTH + 68 + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // hold
    input  logic s_axis_tuser,

    // output stream
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // sample_out, zero pad
    output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int OUT_W = ((SW + 7) / 8) * 8;

    // tdata field offsets
    localparam int TGT_LO = SW;
    localparam int FB_LO  = TGT_LO + TARGET_W;
    localparam int MIX_LO = FB_LO + GAIN_W;

    t_cmd cmd;
    t_sts sts;

    logic signed [SW-1:0] sample_out;

    // controller: clearing pass, then one transaction at a time
    fdh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: store, smoothing, interpolation, feedback, mix and output register
    fdh_datapath #(
        .DELAY_DEPTH  (DELAY_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_sample_in     ($signed(s_axis_tdata[SW-1:0])),
        .i_delay_target  (s_axis_tdata[TGT_LO +: TARGET_W]),
        .i_feedback_gain (s_axis_tdata[FB_LO +: GAIN_W]),
        .i_mix_level     (s_axis_tdata[MIX_LO +: GAIN_W]),
        .i_hold          (s_axis_tuser),
        .o_sample_out    (sample_out),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready)
    );

    // output packing, pad bits zero
    assign m_axis_tdata = OUT_W'($unsigned(sample_out));

    // no transaction is taken while the store is being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear_wr |-> !s_axis_tready)
        else $error("input accepted during clearing pass");

    // one item in flight: after an accepted transaction the input closes
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second item accepted while one is in flight");

    // a result is never written over one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> !(m_axis_tvalid && !m_axis_tready))
        else $error("result overwritten before it was taken");

    // a committed result shows up on the output
    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> m_axis_tvalid)
        else $error("committed result not presented");

endmodule
